FILE: src/sbh_pkg.sv
// Package for the soft-binned histogram: constants, action codes and shared types.
// Used by every module of the block; depends on nothing.
package sbh_pkg;

    localparam int DEF_BINS = 16;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [15:0] RST_RANGE_MIN = 16'h0000;
    localparam logic [15:0] RST_RANGE_MAX = 16'h7FFF;
    localparam logic [15:0] RST_BIN_WIDTH = 16'd2048;

    localparam logic [1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [1:0] REG_BIN_WIDTH = 2'd2;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quotient;
    } div_rsp_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

FILE: src/sbh_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 48 by 32 bits.
// Depends on sbh_pkg for the request and response types.
module sbh_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  sbh_pkg::div_req_t req,
    output sbh_pkg::div_rsp_t rsp
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] shifted;
    logic [33:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg[31:0], quo_reg[47]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            quo_next  = req.dividend;
            rem_next  = 33'd0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: src/sbh_store.sv
// Bin store: synchronous memory of Q16.16 bin weights with a registered read port.
// Depends on sbh_pkg for the default bin count.
module sbh_store
#(
    parameter int BINS = sbh_pkg::DEF_BINS
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [$clog2(BINS)-1:0] waddr,
    input  logic [31:0]             wdata,
    input  logic [$clog2(BINS)-1:0] raddr,
    output logic [31:0]             rdata
);

    logic [31:0] mem [BINS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/soft_binned_histogram.sv
// Top level of the soft-binned histogram: APB registers, sequencer, bin store and divider.
// Depends on sbh_pkg, sbh_store and sbh_div.
//
// An insert keeps busy high through a pass of the serial divider for the
// offset over the bin width, a step for each of the three candidate bins,
// and for each bin that takes weight (at most two, since no more than two bin
// centers lie closer than one bin width) a weight quotient and a write-back,
// then a step to add the total. A sample outside the range and an unused
// action leave busy low. A clear sweeps the store one bin a cycle. A read-out
// runs one divider pass per bin and gives one result transfer per bin with
// last_bin set on the final one. Results appear for one cycle under
// result_valid and cannot be held off. After reset the block clears the
// store before it drops busy; start is taken only while busy is low.
module soft_binned_histogram
#(
    parameter int BINS = sbh_pkg::DEF_BINS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic signed [15:0] sample,
    output logic        result_valid,
    output logic [5:0]  bin_index,
    output logic [16:0] bin_value,
    output logic [31:0] point_count,
    output logic        last_bin
);

    localparam int AW = $clog2(BINS);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_TDIV   = 4'd2;
    localparam logic [3:0] S_NBR    = 4'd3;
    localparam logic [3:0] S_RDWAIT = 4'd4;
    localparam logic [3:0] S_WDIV   = 4'd5;
    localparam logic [3:0] S_WRITE  = 4'd6;
    localparam logic [3:0] S_TOTAL  = 4'd7;
    localparam logic [3:0] S_RREAD  = 4'd8;
    localparam logic [3:0] S_RDIV   = 4'd9;
    localparam logic [3:0] S_ROUT   = 4'd10;

    logic [15:0] rmin_reg, rmax_reg, bw_reg;
    logic        cfg_wr;
    logic [3:0]  st_reg, st_next;
    logic [AW:0] ptr_reg, ptr_next;
    logic [31:0] tot_reg, tot_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] sum_reg, sum_next;
    logic [17:0] off2_reg, off2_next;
    logic [16:0] w_reg, w_next;
    logic [16:0] tgt_reg, tgt_next;
    logic [1:0]  k_reg, k_next;
    logic [31:0] wt_reg, wt_next;
    logic        rv_reg, rv_next;
    logic [5:0]  ri_reg, ri_next;
    logic [16:0] rval_reg, rval_next;
    logic        rl_reg, rl_next;
    logic        st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [31:0] st_wdata, st_rdata;
    sbh_pkg::div_req_t dreq;
    sbh_pkg::div_rsp_t drsp;
    logic signed [17:0] off;
    logic signed [18:0] bidx;
    logic signed [19:0] ctr;
    logic signed [19:0] e_s;
    logic [18:0] e_abs;
    logic [17:0] w2;
    logic [47:0] q;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmin_reg <= sbh_pkg::RST_RANGE_MIN;
            rmax_reg <= sbh_pkg::RST_RANGE_MAX;
            bw_reg   <= sbh_pkg::RST_BIN_WIDTH;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                sbh_pkg::REG_RANGE_MIN: rmin_reg <= pwdata[15:0];
                sbh_pkg::REG_RANGE_MAX: rmax_reg <= pwdata[15:0];
                sbh_pkg::REG_BIN_WIDTH: bw_reg   <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sbh_pkg::REG_RANGE_MIN: prdata = {{16{rmin_reg[15]}}, rmin_reg};
            sbh_pkg::REG_RANGE_MAX: prdata = {{16{rmax_reg[15]}}, rmax_reg};
            sbh_pkg::REG_BIN_WIDTH: prdata = {16'd0, bw_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign off  = 18'(sample) - 18'(signed'(rmin_reg));
    assign bidx = $signed({2'b00, tgt_reg}) + 19'(signed'({1'b0, k_reg})) - 19'sd1;
    assign ctr  = 20'($signed({bidx, 1'b1})) * 20'($signed({3'b000, w_reg}));
    assign e_s  = $signed({2'b00, off2_reg}) - ctr;
    assign e_abs = e_s[19] ? 19'(-e_s) : e_s[18:0];
    assign w2   = {w_reg, 1'b0};
    assign q    = drsp.quotient;

    sbh_store #(.BINS(BINS)) u_store
    (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    sbh_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        st_next   = st_reg;
        ptr_next  = ptr_reg;
        tot_next  = tot_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        off2_next = off2_reg;
        w_next    = w_reg;
        tgt_next  = tgt_reg;
        k_next    = k_reg;
        wt_next   = wt_reg;
        rv_next   = 1'b0;
        ri_next   = ri_reg;
        rval_next = rval_reg;
        rl_next   = 1'b0;
        st_we     = 1'b0;
        st_waddr  = ptr_reg[AW-1:0];
        st_wdata  = 32'd0;
        st_raddr  = ptr_reg[AW-1:0];
        dreq      = '0;
        case (st_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                ptr_next = ptr_reg + (AW+1)'(1);
                if (ptr_reg == (AW+1)'(BINS - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        sbh_pkg::ACT_INSERT:
                        begin
                            if ($signed(sample) >= $signed(rmin_reg) &&
                                $signed(sample) <= $signed(rmax_reg))
                            begin
                                w_next    = (bw_reg == 16'd0) ? 17'd1 : {1'b0, bw_reg};
                                off2_next = {off[16:0], 1'b0};
                                sum_next  = 32'd0;
                                k_next    = 2'd0;
                                cnt_next  = sbh_pkg::sat_add32(cnt_reg, 32'd1);
                                dreq.start    = 1'b1;
                                dreq.dividend = 48'(off[16:0]);
                                dreq.divisor  = (bw_reg == 16'd0) ? 32'd1 : 32'(bw_reg);
                                st_next   = S_TDIV;
                            end
                        end
                        sbh_pkg::ACT_CLEAR:
                        begin
                            tot_next = 32'd0;
                            cnt_next = 32'd0;
                            ptr_next = '0;
                            st_next  = S_CLEAR;
                        end
                        sbh_pkg::ACT_READ:
                        begin
                            ptr_next = '0;
                            st_next  = S_RREAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_TDIV:
            begin
                if (drsp.done)
                begin
                    tgt_next = q[16:0];
                    st_next  = S_NBR;
                end
            end
            S_NBR:
            begin
                if (bidx >= 19'sd0 && bidx < 19'(BINS) && e_abs < 19'(w2))
                begin
                    st_raddr = bidx[AW-1:0];
                    ptr_next = (AW+1)'(bidx[AW-1:0]);
                    dreq.start    = 1'b1;
                    dreq.dividend = {14'd0, 18'(w2 - e_abs[17:0]), 16'd0};
                    dreq.divisor  = 32'(w2);
                    st_next = S_WDIV;
                end
                else if (k_reg == 2'd2)
                begin
                    st_next = S_TOTAL;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_WDIV:
            begin
                if (drsp.done)
                begin
                    wt_next = q[31:0];
                    st_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                st_we    = 1'b1;
                st_wdata = sbh_pkg::sat_add32(st_rdata, wt_reg);
                sum_next = sbh_pkg::sat_add32(sum_reg, wt_reg);
                if (k_reg == 2'd2)
                begin
                    st_next = S_TOTAL;
                end
                else
                begin
                    k_next  = k_reg + 2'd1;
                    st_next = S_NBR;
                end
            end
            S_TOTAL:
            begin
                tot_next = sbh_pkg::sat_add32(tot_reg, sum_reg);
                st_next  = S_IDLE;
            end
            S_RREAD:
            begin
                st_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = {st_rdata, 16'd0};
                dreq.divisor  = (tot_reg == 32'd0) ? 32'd1 : tot_reg;
                st_next = S_RDIV;
            end
            S_RDIV:
            begin
                if (drsp.done)
                begin
                    if (tot_reg == 32'd0)
                    begin
                        rval_next = 17'd0;
                    end
                    else if (q > 48'd65536)
                    begin
                        rval_next = 17'd65536;
                    end
                    else
                    begin
                        rval_next = q[16:0];
                    end
                    st_next = S_ROUT;
                end
            end
            S_ROUT:
            begin
                rv_next  = 1'b1;
                ri_next  = 6'(ptr_reg);
                rl_next  = (ptr_reg == (AW+1)'(BINS - 1));
                ptr_next = ptr_reg + (AW+1)'(1);
                st_next  = (ptr_reg == (AW+1)'(BINS - 1)) ? S_IDLE : S_RREAD;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLEAR;
            ptr_reg <= '0;
            tot_reg <= 32'd0;
            cnt_reg <= 32'd0;
            rv_reg  <= 1'b0;
            rl_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            ptr_reg <= ptr_next;
            tot_reg <= tot_next;
            cnt_reg <= cnt_next;
            rv_reg  <= rv_next;
            rl_reg  <= rl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        off2_reg <= off2_next;
        w_reg    <= w_next;
        tgt_reg  <= tgt_next;
        k_reg    <= k_next;
        wt_reg   <= wt_next;
        ri_reg   <= ri_next;
        rval_reg <= rval_next;
    end

    assign busy         = (st_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign bin_index    = ri_reg;
    assign bin_value    = rval_reg;
    assign point_count  = cnt_reg;
    assign last_bin     = rl_reg;

    property p_last_has_valid;
        @(posedge clk) disable iff (!rst_n) last_bin |-> result_valid;
    endproperty
    assert property (p_last_has_valid) else $error("last_bin without result");

    property p_no_result_idle;
        @(posedge clk) disable iff (!rst_n) (st_reg == S_IDLE && !result_valid) |=> !result_valid;
    endproperty
    assert property (p_no_result_idle) else $error("result outside read-out");

    property p_value_bound;
        @(posedge clk) disable iff (!rst_n) result_valid |-> bin_value <= 17'd65536;
    endproperty
    assert property (p_value_bound) else $error("bin_value above one");

    property p_write_in_bounds;
        @(posedge clk) disable iff (!rst_n) st_we |-> ptr_reg < (AW+1)'(BINS);
    endproperty
    assert property (p_write_in_bounds) else $error("store write out of range");

endmodule
